// File: hw/rtl/mrxy_pkg.sv
// ----------------------------------------------------------------------------
// mrxy_pkg
// Shared types, codes and defaults of the XY mesh router with credit flow.
// ----------------------------------------------------------------------------
package mrxy_pkg;

    localparam int NUM_IN_PORTS    = 5;
    localparam int DEF_NET_DEPTH   = 32;
    localparam int DEF_INJ_DEPTH   = 1024;
    localparam int CFG_W           = 11;
    localparam int CMPW            = 16;

    localparam logic [2:0] PORT_N     = 3'd0;
    localparam logic [2:0] PORT_E     = 3'd1;
    localparam logic [2:0] PORT_S     = 3'd2;
    localparam logic [2:0] PORT_W     = 3'd3;
    localparam logic [2:0] PORT_LOCAL = 3'd4;

    localparam logic [1:0] KIND_FLIT   = 2'd0;
    localparam logic [1:0] KIND_CREDIT = 2'd1;
    localparam logic [1:0] KIND_ARB    = 2'd2;
    localparam logic [1:0] KIND_RSVD   = 2'd3;

    localparam logic [2:0] CFG_ROUTER_ID = 3'd0;
    localparam logic [2:0] CFG_MY_X      = 3'd1;
    localparam logic [2:0] CFG_MY_Y      = 3'd2;
    localparam logic [2:0] CFG_MESH_W    = 3'd3;
    localparam logic [2:0] CFG_MESH_H    = 3'd4;
    localparam logic [2:0] CFG_NET_BUF   = 3'd5;
    localparam logic [2:0] CFG_INJ_BUF   = 3'd6;

    localparam logic [5:0] CREDIT_MAX    = 6'd63;
    localparam logic [5:0] CREDIT_RESET  = 6'd32;

    typedef struct packed {
        logic [7:0]         dest;
        logic [11:0]        neuron;
        logic signed [15:0] weight;
        logic [15:0]        tag;
    } flit_t;

    typedef struct packed {
        logic load;
        logic simple;
        logic rd_issue;
        logic div_start;
        logic div_step;
        logic finish;
    } mrxy_cmd_t;

    typedef struct packed {
        logic is_arb;
        logic has_winner;
        logic div_last;
        logic out_free;
    } mrxy_status_t;

    function automatic logic [2:0] next_port(input logic [2:0] p);
        logic [2:0] r;
        if (p >= PORT_LOCAL)
        begin
            r = PORT_N;
        end
        else
        begin
            r = p + 3'd1;
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/mesh_router_xy_credit_top.sv
// ----------------------------------------------------------------------------
// mesh_router_xy_credit_top
// Five-port XY mesh router with input queues, round robin and credits.
// ----------------------------------------------------------------------------
// Each input transaction is one of: a flit arriving on a port, a credit
// returning for a network output, or one arbitration cycle; each yields
// exactly one output transaction. Arrivals, credits, reserved kinds and an
// arbitration cycle that finds every queue empty go from acceptance to
// result through latch, then execute. An arbitration cycle that finds a
// queued flit goes through latch, pick the winner and issue the queue
// read, read data, eight steps of the bit-serial division that splits
// the destination id into column and row, then the route and credit
// decision. The output register holds a finished result while the next
// transaction is accepted; a result waits in its last step only while that
// register is still occupied and stalled.
// Queues use block memories: one of four times NET_DEPTH flits for the
// network ports and one of INJ_DEPTH flits for the local port.
module mesh_router_xy_credit_top #(
    parameter int NET_DEPTH = mrxy_pkg::DEF_NET_DEPTH,
    parameter int INJ_DEPTH = mrxy_pkg::DEF_INJ_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [2:0]                 cfg_index,
    input  logic [mrxy_pkg::CFG_W-1:0] cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 kind,
    input  logic [2:0]                 port,
    input  logic [7:0]                 dest_router,
    input  logic [11:0]                dest_neuron,
    input  logic signed [15:0]         weight,
    input  logic [15:0]                flit_tag,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       fwd_valid,
    output logic [2:0]                 egress_port,
    output logic [7:0]                 out_dest_router,
    output logic [11:0]                out_dest_neuron,
    output logic signed [15:0]         out_weight,
    output logic [15:0]                out_tag,
    output logic                       credit_valid,
    output logic [1:0]                 credit_port,
    output logic                       stalled,
    output logic                       dropped
);
    import mrxy_pkg::*;

    mrxy_cmd_t    cmd;
    mrxy_status_t st;
    flit_t        in_flit;
    flit_t        out_flit;

    // pack the arriving flit fields
    assign in_flit.dest   = dest_router;
    assign in_flit.neuron = dest_neuron;
    assign in_flit.weight = weight;
    assign in_flit.tag    = flit_tag;

    // sequencer: advance one transaction through its steps
    mrxy_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // datapath: hold queues, credits and the result register
    mrxy_dp #(
        .NET_DEPTH (NET_DEPTH),
        .INJ_DEPTH (INJ_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .kind         (kind),
        .port         (port),
        .in_flit      (in_flit),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .fwd_valid    (fwd_valid),
        .egress_port  (egress_port),
        .out_flit     (out_flit),
        .credit_valid (credit_valid),
        .credit_port  (credit_port),
        .stalled      (stalled),
        .dropped      (dropped)
    );

    // unpack the forwarded flit
    assign out_dest_router = out_flit.dest;
    assign out_dest_neuron = out_flit.neuron;
    assign out_weight      = out_flit.weight;
    assign out_tag         = out_flit.tag;

endmodule

// File: hw/rtl/mrxy_ctrl.sv
// ----------------------------------------------------------------------------
// mrxy_ctrl
// Sequencer: accept, execute, queue read, division steps, route decision.
// ----------------------------------------------------------------------------
module mrxy_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  mrxy_pkg::mrxy_status_t st,
    output mrxy_pkg::mrxy_cmd_t    cmd
);
    import mrxy_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_DIV,
        S_DECIDE
    } state_t;

    state_t state_reg, state_next;
    logic   in_stall_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (st.is_arb && st.has_winner)
                begin
                    cmd.rd_issue = 1'b1;
                    state_next   = S_READ;
                end
                else if (st.out_free)
                begin
                    cmd.simple = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_last)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (st.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_stall_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_stall_reg <= (state_next != S_IDLE);
        end
    end

    assign in_stall = in_stall_reg;

endmodule

// File: hw/rtl/mrxy_dp.sv
// ----------------------------------------------------------------------------
// mrxy_dp
// Datapath: queues, counters, credits, arbiter, divider and output register.
// ----------------------------------------------------------------------------
module mrxy_dp #(
    parameter int NET_DEPTH = mrxy_pkg::DEF_NET_DEPTH,
    parameter int INJ_DEPTH = mrxy_pkg::DEF_INJ_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mrxy_pkg::mrxy_cmd_t         cmd,
    output mrxy_pkg::mrxy_status_t      st,
    input  logic                       cfg_we,
    input  logic [2:0]                 cfg_index,
    input  logic [mrxy_pkg::CFG_W-1:0] cfg_data,
    input  logic [1:0]                 kind,
    input  logic [2:0]                 port,
    input  mrxy_pkg::flit_t             in_flit,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       fwd_valid,
    output logic [2:0]                 egress_port,
    output mrxy_pkg::flit_t             out_flit,
    output logic                       credit_valid,
    output logic [1:0]                 credit_port,
    output logic                       stalled,
    output logic                       dropped
);
    import mrxy_pkg::*;

    localparam int NPW = $clog2(NET_DEPTH);
    localparam int IPW = $clog2(INJ_DEPTH);
    localparam int HW  = (NPW > IPW) ? NPW : IPW;
    localparam int MAXD = (NET_DEPTH > INJ_DEPTH) ? NET_DEPTH : INJ_DEPTH;
    localparam int CW  = $clog2(MAXD + 1);
    localparam logic [CMPW-1:0] NET_D = CMPW'(NET_DEPTH);
    localparam logic [CMPW-1:0] INJ_D = CMPW'(INJ_DEPTH);

    // configuration
    logic [7:0]       router_id_reg;
    logic [3:0]       my_x_reg, my_y_reg;
    logic [4:0]       mesh_w_reg, mesh_h_reg;
    logic [10:0]      inj_buf_reg;

    // queue bookkeeping
    logic [CW-1:0]    count_reg [NUM_IN_PORTS];
    logic [HW-1:0]    head_reg  [NUM_IN_PORTS];
    logic [5:0]       credit_reg [4];
    logic [2:0]       lw_reg;
    logic [2:0]       win_reg;

    // latched item
    logic [1:0]       kind_reg;
    logic [2:0]       port_reg;
    flit_t            item_reg;

    // storage
    flit_t            net_mem [4][NET_DEPTH];
    flit_t            loc_mem [INJ_DEPTH];
    flit_t            net_rd_reg, loc_rd_reg, head_flit;

    // divider
    logic [4:0]       rem_reg;
    logic [7:0]       quo_reg;
    logic [2:0]       div_cnt_reg;
    logic [4:0]       divisor;
    logic [5:0]       div_tmp;
    logic             div_ge;

    // output register
    logic             out_valid_reg;
    logic             fwd_valid_reg, credit_valid_reg, stalled_reg, dropped_reg;
    logic [2:0]       egress_port_reg;
    logic [1:0]       credit_port_reg;
    flit_t            out_flit_reg;
    logic             out_free;

    // combinational decisions
    logic             found;
    logic [2:0]       win_c, scan_p;
    logic             port_ok, full;
    logic [CMPW-1:0]  cap, cnt16, wsum, depth_p;
    logic [HW-1:0]    waddr;
    logic [CMPW-1:0]  wdepth, hnext;
    logic [HW-1:0]    head_pop;
    logic [2:0]       op;
    logic             op_blocked, nb_op_ok, nb_win_ok;

    assign out_free = !out_valid_reg || !out_stall;

    assign st.is_arb     = (kind_reg == KIND_ARB);
    assign st.has_winner = found;
    assign st.div_last   = (div_cnt_reg == 3'd7);
    assign st.out_free   = out_free;

    // round robin after the last winner
    always_comb
    begin
        scan_p = lw_reg;
        found  = 1'b0;
        win_c  = PORT_N;
        for (int i = 0; i < NUM_IN_PORTS; i++)
        begin
            scan_p = next_port(scan_p);
            if (!found && (count_reg[scan_p] != '0))
            begin
                found = 1'b1;
                win_c = scan_p;
            end
        end
    end

    // arrival: capacity and tail slot
    always_comb
    begin
        port_ok = (port_reg <= PORT_LOCAL);
        cnt16   = port_ok ? CMPW'(count_reg[port_reg]) : '0;
        if (port_reg == PORT_LOCAL)
        begin
            cap     = (CMPW'(inj_buf_reg) < INJ_D) ? CMPW'(inj_buf_reg) : INJ_D;
            depth_p = INJ_D;
        end
        else
        begin
            cap     = NET_D;
            depth_p = NET_D;
        end
        full = (cnt16 >= cap);
        wsum = (port_ok ? CMPW'(head_reg[port_reg]) : '0) + cnt16;
        if (wsum >= depth_p)
        begin
            wsum = wsum - depth_p;
        end
        waddr = wsum[HW-1:0];
    end

    // neighbor id across a port lies inside the mesh
    function automatic logic nb_ok(input logic [2:0] p, input logic [7:0] id,
                                   input logic [4:0] w, input logic [4:0] h);
        logic signed [11:0] n;
        logic [9:0]         total;
        logic               ok;
        total = w * h;
        case (p)
            PORT_N:  n = $signed({4'd0, id}) - $signed({7'd0, w});
            PORT_E:  n = $signed({4'd0, id}) + 12'sd1;
            PORT_S:  n = $signed({4'd0, id}) + $signed({7'd0, w});
            PORT_W:  n = $signed({4'd0, id}) - 12'sd1;
            default: n = -12'sd1;
        endcase
        ok = (n >= 12'sd0) && (n < $signed({2'd0, total}));
        return ok;
    endfunction

    // route decision from the division result
    always_comb
    begin
        head_flit = (win_reg == PORT_LOCAL) ? loc_rd_reg : net_rd_reg;
        if ({3'd0, rem_reg} > {4'd0, my_x_reg})
        begin
            op = PORT_E;
        end
        else if ({3'd0, rem_reg} < {4'd0, my_x_reg})
        begin
            op = PORT_W;
        end
        else if (quo_reg > {4'd0, my_y_reg})
        begin
            op = PORT_S;
        end
        else if (quo_reg < {4'd0, my_y_reg})
        begin
            op = PORT_N;
        end
        else
        begin
            op = PORT_LOCAL;
        end
        op_blocked = (op != PORT_LOCAL) && (credit_reg[op[1:0]] == '0);
        nb_op_ok   = (op == PORT_LOCAL) ||
                     nb_ok(op, router_id_reg, mesh_w_reg, mesh_h_reg);
        nb_win_ok  = (win_reg != PORT_LOCAL) &&
                     nb_ok(win_reg, router_id_reg, mesh_w_reg, mesh_h_reg);
        wdepth     = (win_reg == PORT_LOCAL) ? INJ_D : NET_D;
        hnext      = CMPW'(head_reg[win_reg]) + 16'd1;
        head_pop   = (hnext == wdepth) ? '0 : hnext[HW-1:0];
    end

    // divider step
    always_comb
    begin
        divisor = (mesh_w_reg == '0) ? 5'd1 : mesh_w_reg;
        div_tmp = {rem_reg, quo_reg[7]};
        div_ge  = (div_tmp >= {1'b0, divisor});
    end

    // queue memories
    always_ff @(posedge clk)
    begin
        if (cmd.simple && (kind_reg == KIND_FLIT) && port_ok && !full)
        begin
            if (port_reg == PORT_LOCAL)
            begin
                loc_mem[waddr[IPW-1:0]] <= item_reg;
            end
            else
            begin
                net_mem[port_reg[1:0]][waddr[NPW-1:0]] <= item_reg;
            end
        end
        if (cmd.rd_issue)
        begin
            loc_rd_reg <= loc_mem[head_reg[PORT_LOCAL][IPW-1:0]];
            net_rd_reg <= net_mem[win_c[1:0]][head_reg[win_c][NPW-1:0]];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            port_reg <= port;
            item_reg <= in_flit;
        end
        if (cmd.rd_issue)
        begin
            win_reg <= win_c;
        end
        if (cmd.div_start)
        begin
            rem_reg     <= '0;
            quo_reg     <= head_flit.dest;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= div_ge ? 5'(div_tmp - {1'b0, divisor}) : div_tmp[4:0];
            quo_reg     <= {quo_reg[6:0], div_ge};
            div_cnt_reg <= div_cnt_reg + 3'd1;
        end
    end

    // control state, configuration and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            router_id_reg <= '0;
            my_x_reg      <= '0;
            my_y_reg      <= '0;
            mesh_w_reg    <= 5'd4;
            mesh_h_reg    <= 5'd4;
            inj_buf_reg   <= 11'd1024;
            for (int i = 0; i < NUM_IN_PORTS; i++)
            begin
                count_reg[i] <= '0;
                head_reg[i]  <= '0;
            end
            for (int i = 0; i < 4; i++)
            begin
                credit_reg[i] <= CREDIT_RESET;
            end
            lw_reg           <= PORT_W;
            out_valid_reg    <= 1'b0;
            fwd_valid_reg    <= 1'b0;
            credit_valid_reg <= 1'b0;
            stalled_reg      <= 1'b0;
            dropped_reg      <= 1'b0;
            egress_port_reg  <= '0;
            credit_port_reg  <= '0;
            out_flit_reg     <= '0;
        end
        else
        begin
            if (cmd.simple || cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ROUTER_ID: router_id_reg <= cfg_data[7:0];
                    CFG_MY_X:      my_x_reg      <= cfg_data[3:0];
                    CFG_MY_Y:      my_y_reg      <= cfg_data[3:0];
                    CFG_MESH_W:    mesh_w_reg    <= cfg_data[4:0];
                    CFG_MESH_H:    mesh_h_reg    <= cfg_data[4:0];
                    CFG_NET_BUF:
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            credit_reg[i] <= cfg_data[5:0];
                        end
                    end
                    CFG_INJ_BUF:   inj_buf_reg   <= cfg_data[10:0];
                    default:       ;
                endcase
            end
            if (cmd.simple)
            begin
                fwd_valid_reg    <= 1'b0;
                credit_valid_reg <= 1'b0;
                stalled_reg      <= 1'b0;
                dropped_reg      <= (kind_reg == KIND_FLIT) && port_ok && full;
                egress_port_reg  <= '0;
                credit_port_reg  <= '0;
                out_flit_reg     <= '0;
                if ((kind_reg == KIND_FLIT) && port_ok)
                begin
                    if (!full)
                    begin
                        count_reg[port_reg] <= count_reg[port_reg] + CW'(1);
                    end
                end
                else if ((kind_reg == KIND_CREDIT) && (port_reg < PORT_LOCAL))
                begin
                    if (credit_reg[port_reg[1:0]] < CREDIT_MAX)
                    begin
                        credit_reg[port_reg[1:0]] <= credit_reg[port_reg[1:0]] + 6'd1;
                    end
                end
            end
            if (cmd.finish)
            begin
                lw_reg           <= win_reg;
                egress_port_reg  <= op;
                dropped_reg      <= 1'b0;
                stalled_reg      <= op_blocked;
                fwd_valid_reg    <= !op_blocked && nb_op_ok;
                out_flit_reg     <= (!op_blocked && nb_op_ok) ? head_flit : '0;
                credit_valid_reg <= !op_blocked && nb_win_ok;
                credit_port_reg  <= (!op_blocked && nb_win_ok) ? win_reg[1:0] : 2'd0;
                if (!op_blocked)
                begin
                    head_reg[win_reg]  <= head_pop;
                    count_reg[win_reg] <= count_reg[win_reg] - CW'(1);
                    if (op != PORT_LOCAL)
                    begin
                        credit_reg[op[1:0]] <= credit_reg[op[1:0]] - 6'd1;
                    end
                end
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign fwd_valid    = fwd_valid_reg;
    assign egress_port  = egress_port_reg;
    assign out_flit     = out_flit_reg;
    assign credit_valid = credit_valid_reg;
    assign credit_port  = credit_port_reg;
    assign stalled      = stalled_reg;
    assign dropped      = dropped_reg;

endmodule
